// ----- rtl/core/sbfr_pkg.sv -----
// Shared types and constants for the serial bus frame receiver.
// Depends on nothing; every other file in rtl/core imports it.
package sbfr_pkg;

	localparam int unsigned DEF_NUM_CHANNELS = 16;
	localparam int unsigned IDX_W            = 4;
	localparam int unsigned VAL_W            = 11;
	localparam int unsigned STORE_LEN        = 23;
	localparam int unsigned STORE_W          = STORE_LEN * 8;
	localparam int unsigned PAYLOAD_W        = 176;
	localparam int unsigned POS_W            = 5;
	localparam int unsigned FQ_DEPTH         = 2;

	localparam logic [7:0]       HDR_BYTE     = 8'h0F;
	localparam logic [7:0]       END_BYTE     = 8'h00;
	localparam logic [POS_W-1:0] END_POS      = 5'd24;
	localparam logic [POS_W-1:0] LAST_DATA    = 5'd23;
	localparam int unsigned      FLAG_LOST    = 2;
	localparam int unsigned      FLAG_FAILSAFE = 3;

	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_IDLE = 1'b1;

	typedef enum logic [1:0] {
		LINK_OK       = 2'd0,
		LINK_LOST     = 2'd1,
		LINK_FAILSAFE = 2'd2
	} link_status_t;

	// One accepted frame as handed from the parser to the unpacker.
	typedef struct packed {
		logic [PAYLOAD_W-1:0] payload;
		link_status_t         status;
	} frame_t;

endpackage

// ----- rtl/core/sbfr_front.sv -----
// Frame parser: hunts for the header, collects the data bytes and checks the end byte.
// Depends on sbfr_pkg.
module sbfr_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  logic           func,
	input  logic [7:0]     rx_byte,
	input  logic           fq_full,
	output logic           fq_push,
	output sbfr_pkg::frame_t fq_data
);
	import sbfr_pkg::*;

	logic                   in_frame_q;
	logic [POS_W-1:0]       pos_q;
	logic [STORE_W-1:0]     store_q;
	logic                   accept;
	logic [POS_W-1:0]       pos_next;
	logic [7:0]             flags;
	link_status_t           status;

	assign accept   = push && !fq_full;
	assign pos_next = pos_q + POS_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q      <= '0;
		end else if (accept) begin
			if (func == FUNC_IDLE) begin
				in_frame_q <= 1'b0;
				pos_q      <= '0;
			end else if (!in_frame_q) begin
				if (rx_byte == HDR_BYTE) begin
					in_frame_q <= 1'b1;
					pos_q      <= '0;
				end
			end else if (pos_next == END_POS) begin
				in_frame_q <= 1'b0;
				pos_q      <= '0;
			end else begin
				pos_q <= pos_next;
			end
		end
	end

	// Data bytes shift in from the top, so byte 1 ends up in the lowest lane.
	always_ff @(posedge clk) begin
		if (accept && func == FUNC_BYTE && in_frame_q && pos_next <= LAST_DATA) begin
			store_q <= {rx_byte, store_q[STORE_W-1:8]};
		end
	end

	assign flags = store_q[STORE_W-1 -: 8];

	always_comb begin
		priority if (flags[FLAG_FAILSAFE]) status = LINK_FAILSAFE;
		else if (flags[FLAG_LOST])         status = LINK_LOST;
		else                               status = LINK_OK;
	end

	assign fq_push = accept && func == FUNC_BYTE && in_frame_q && pos_next == END_POS
		&& rx_byte == END_BYTE;
	assign fq_data.payload = store_q[PAYLOAD_W-1:0];
	assign fq_data.status  = status;

endmodule

// ----- rtl/core/sbfr_frame_fifo.sv -----
// Short queue of whole frames between the parser and the unpacker.
// Depends on sbfr_pkg.
module sbfr_frame_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  sbfr_pkg::frame_t wr_data,
	input  logic             rd_en,
	output logic             full,
	output logic             empty,
	output sbfr_pkg::frame_t rd_data
);
	import sbfr_pkg::*;

	localparam int unsigned PTR_W = $clog2(FQ_DEPTH);

	frame_t                 mem_q [FQ_DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [PTR_W:0]         count_q;

	assign full    = count_q == (PTR_W+1)'(FQ_DEPTH);
	assign empty   = count_q == '0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (rd_en) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (wr_en && !rd_en)      count_q <= count_q + (PTR_W+1)'(1);
			else if (rd_en && !wr_en) count_q <= count_q - (PTR_W+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

// ----- rtl/core/sbfr_back.sv -----
// Channel unpacker: peels one 11-bit channel a cycle off a queued frame, unless an unpopped output word holds it.
// Depends on sbfr_pkg.
module sbfr_back #(
	parameter int unsigned NUM_CHANNELS = sbfr_pkg::DEF_NUM_CHANNELS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      fq_empty,
	input  sbfr_pkg::frame_t          fq_data,
	output logic                      fq_pop,
	input  logic                      pop,
	output logic                      empty,
	output logic [sbfr_pkg::IDX_W-1:0] channel_index,
	output logic [sbfr_pkg::VAL_W-1:0] channel_value,
	output logic [1:0]                link_status,
	output logic                      last_channel
);
	import sbfr_pkg::*;

	logic                 active_q;
	logic [IDX_W-1:0]     cnt_q;
	logic                 out_valid_q;
	logic [PAYLOAD_W-1:0] sh_q;
	link_status_t         status_q;
	logic [IDX_W-1:0]     idx_q;
	logic [VAL_W-1:0]     val_q;
	link_status_t         stat_q;
	logic                 last_q;
	logic                 adv;
	logic                 is_last;

	assign fq_pop  = !active_q && !fq_empty;
	assign adv     = active_q && (!out_valid_q || pop);
	assign is_last = cnt_q == IDX_W'(NUM_CHANNELS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fq_pop) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (adv) begin
				cnt_q <= cnt_q + IDX_W'(1);
				if (is_last) begin
					active_q <= 1'b0;
					cnt_q    <= '0;
				end
			end
			if (adv)      out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fq_pop) begin
			sh_q     <= fq_data.payload;
			status_q <= fq_data.status;
		end else if (adv) begin
			sh_q <= sh_q >> VAL_W;
		end
		if (adv) begin
			idx_q  <= cnt_q;
			val_q  <= sh_q[VAL_W-1:0];
			stat_q <= status_q;
			last_q <= is_last;
		end
	end

	assign empty         = !out_valid_q;
	assign channel_index = idx_q;
	assign channel_value = val_q;
	assign link_status   = stat_q;
	assign last_channel  = last_q;

endmodule

// ----- rtl/core/sbus_frame_receiver.sv -----
// Top level of the serial bus frame receiver: parser, frame queue and unpacker.
// Depends on sbfr_pkg, sbfr_front, sbfr_frame_fifo and sbfr_back.
//
//  Channel   Handshake        Word
//  ------    ---------------  ------------------------------------------------
//  input     push / full      func, rx_byte
//  result    empty / pop      channel_index, channel_value, link_status,
//                             last_channel
//
// One input word is taken every cycle while full is low; the parser works on
// it in that same cycle. A frame accepted on its end byte enters a two-deep
// frame queue; the unpacker loads it from the queue and then delivers one
// channel word per cycle while its output word is popped. full rises only
// while the frame queue holds two frames, which happens when the result side
// stalls. The output register holds a finished word until it is popped; the
// unpacker waits only while that word is left unpopped, and a pop lets the
// next word in behind it in the same cycle. Reset (arst_n low) puts the
// parser back to hunting and empties the queue and the output; the frame
// store needs no clearing, since a frame is only passed on after all of its
// bytes have been written.
module sbus_frame_receiver #(
	parameter int unsigned NUM_CHANNELS = sbfr_pkg::DEF_NUM_CHANNELS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic                       func,
	input  logic [7:0]                 rx_byte,
	output logic                       empty,
	input  logic                       pop,
	output logic [sbfr_pkg::IDX_W-1:0] channel_index,
	output logic [sbfr_pkg::VAL_W-1:0] channel_value,
	output logic [1:0]                 link_status,
	output logic                       last_channel
);
	import sbfr_pkg::*;

	// Signals between the parser, the frame queue and the unpacker.
	logic   fq_push;
	logic   fq_pop;
	logic   fq_full;
	logic   fq_empty;
	frame_t fq_wr_data;
	frame_t fq_rd_data;

	// The parser stalls whenever the frame queue is full, whatever word it is offered.
	assign full = fq_full;

	sbfr_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.func    (func),
		.rx_byte (rx_byte),
		.fq_full (fq_full),
		.fq_push (fq_push),
		.fq_data (fq_wr_data)
	);

	sbfr_frame_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fq_push),
		.wr_data (fq_wr_data),
		.rd_en   (fq_pop),
		.full    (fq_full),
		.empty   (fq_empty),
		.rd_data (fq_rd_data)
	);

	sbfr_back #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.fq_empty      (fq_empty),
		.fq_data       (fq_rd_data),
		.fq_pop        (fq_pop),
		.pop           (pop),
		.empty         (empty),
		.channel_index (channel_index),
		.channel_value (channel_value),
		.link_status   (link_status),
		.last_channel  (last_channel)
	);

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for sbus_frame_receiver: byte and line-idle words in, channel words out.
// Depends on sbfr_pkg and the RTL under rtl/core; it needs no other file.
module tb_top;
	import sbfr_pkg::*;

	localparam int unsigned NCH           = DEF_NUM_CHANNELS;
	// Input words offered over the whole run, directed tests included.
	localparam int unsigned ITEM_TARGET   = 420;
	localparam int unsigned CYCLE_LIMIT   = 200000;
	// Long enough for one frame to leave the queue and the unpacker, with margin.
	localparam int unsigned SETTLE_CYCLES = 2 * NCH + 8;
	localparam int unsigned REPORT_MAX    = 10;
	localparam int unsigned IDLE_PERCENT  = 8;

	// How the 22 payload bytes of a generated frame are filled.
	typedef enum int unsigned {
		FILL_RANDOM,
		FILL_ZERO,
		FILL_ONES,
		FILL_MIXED
	} fill_t;

	// One channel word as the block should deliver it.
	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic [VAL_W-1:0] value;
		link_status_t     status;
		logic             last;
	} channel_word_t;

	logic             clk     = 1'b0;
	logic             arst_n  = 1'b0;
	logic             push    = 1'b0;
	logic             func    = FUNC_BYTE;
	logic [7:0]       rx_byte = 8'h00;
	logic             pop     = 1'b0;
	logic             full;
	logic             empty;
	logic [IDX_W-1:0] channel_index;
	logic [VAL_W-1:0] channel_value;
	logic [1:0]       link_status;
	logic             last_channel;

	// Our own copy of the parser state: whether a frame is open, how many bytes
	// have followed its header, and the bytes stored so far.
	logic             in_frame = 1'b0;
	logic [POS_W-1:0] frame_pos = '0;
	logic [7:0]       frame_bytes [STORE_LEN];

	// Channel words still owed by the block, oldest first.
	channel_word_t    pending_channels [$];

	// When set, neither side idles: used for the steady stretch of the run.
	bit               steady = 1'b0;

	int unsigned      cycles = 0;
	int unsigned      words_taken = 0;
	int unsigned      live_words = 0;
	int unsigned      frames_decoded = 0;
	int unsigned      frames_rejected = 0;
	int unsigned      channels_checked = 0;
	int unsigned      mismatches = 0;

	sbus_frame_receiver #(
		.NUM_CHANNELS(NCH)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.func         (func),
		.rx_byte      (rx_byte),
		.empty        (empty),
		.pop          (pop),
		.channel_index(channel_index),
		.channel_value(channel_value),
		.link_status  (link_status),
		.last_channel (last_channel)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// The run is cut short here if the block stops delivering words.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Decodes one accepted input word into our copy of the state. A word that
	// completes a frame with a good end byte appends all of its channel words
	// to the pending queue. live_words counts only the words that the block
	// does not simply drop while hunting.
	function automatic void decode_word(input logic f, input logic [7:0] b);
		logic [PAYLOAD_W-1:0] payload;
		link_status_t         status;
		channel_word_t        cw;
		words_taken++;
		if (f == FUNC_IDLE) begin
			// A gap on the line abandons any partial frame.
			if (in_frame)
				live_words++;
			in_frame  = 1'b0;
			frame_pos = '0;
		end else if (!in_frame) begin
			if (b == HDR_BYTE) begin
				in_frame  = 1'b1;
				frame_pos = '0;
				live_words++;
			end
		end else begin
			// Inside a frame every byte is data, the header value included.
			live_words++;
			frame_pos = frame_pos + 1'b1;
			if (frame_pos <= LAST_DATA) begin
				frame_bytes[frame_pos - 1'b1] = b;
			end else begin
				in_frame  = 1'b0;
				frame_pos = '0;
				if (b != END_BYTE) begin
					frames_rejected++;
				end else begin
					frames_decoded++;
					// Channels are packed little-endian from bit 0 of the first
					// payload byte, eleven bits each.
					for (int k = 0; k < STORE_LEN - 1; k++)
						payload[k*8 +: 8] = frame_bytes[k];
					// Failsafe takes precedence over a lost signal.
					status = LINK_OK;
					if (frame_bytes[STORE_LEN-1][FLAG_LOST])
						status = LINK_LOST;
					if (frame_bytes[STORE_LEN-1][FLAG_FAILSAFE])
						status = LINK_FAILSAFE;
					for (int ch = 0; ch < NCH; ch++) begin
						cw.index  = IDX_W'(ch);
						cw.value  = payload[ch*VAL_W +: VAL_W];
						cw.status = status;
						cw.last   = (ch == NCH - 1);
						pending_channels.push_back(cw);
					end
				end
			end
		end
	endfunction

	function automatic void flag_failure(input string what);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("%0t ns: %s", $time, what);
	endfunction

	// The result side: pop is redrawn on every edge, so stalls land anywhere
	// within a frame's burst of channel words.
	always @(posedge clk) begin
		if (!arst_n)
			pop <= 1'b0;
		else
			pop <= steady || ($urandom_range(99) >= IDLE_PERCENT);
	end

	// Every word taken from the block is compared with the oldest one owed.
	always @(posedge clk) begin
		channel_word_t want;
		channel_word_t got;
		if (arst_n && pop && !empty) begin
			got = '{channel_index, channel_value, link_status_t'(link_status), last_channel};
			if (pending_channels.size() == 0) begin
				flag_failure($sformatf("unexpected channel word: index %0d value %0d status %0d last %0d",
					got.index, got.value, got.status, got.last));
			end else begin
				want = pending_channels.pop_front();
				channels_checked++;
				if (got !== want)
					flag_failure($sformatf({"channel word mismatch: expected index %0d value %0d ",
						"status %0d last %0d, got index %0d value %0d status %0d last %0d"},
						want.index, want.value, want.status, want.last,
						got.index, got.value, got.status, got.last));
			end
		end
	end

	// Offers one word and returns at the edge that accepts it. push is left
	// high, so back-to-back words follow one another without a gap; a random pause lowers it
	// for one cycle first, which puts gaps between any two bytes of a frame.
	task automatic send_word(input logic f, input logic [7:0] b);
		if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push    <= 1'b1;
		func    <= f;
		rx_byte <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		decode_word(f, b);
	endtask

	// A whole 25-byte frame: header, 22 payload bytes, the flag byte and the end byte.
	task automatic send_frame(input fill_t fill, input logic [7:0] flags, input logic [7:0] tail);
		logic [7:0] b;
		send_word(FUNC_BYTE, HDR_BYTE);
		for (int k = 0; k < STORE_LEN - 1; k++) begin
			case (fill)
				FILL_ZERO: b = 8'h00;
				FILL_ONES: b = 8'hFF;
				FILL_MIXED: begin
					case (k % 4)
						0: b = 8'hFF;
						1: b = 8'h00;
						2: b = HDR_BYTE;
						default: b = 8'($urandom_range(255));
					endcase
				end
				default: begin
					// Now and then a header value lands in the payload.
					b = ($urandom_range(99) < 10) ? HDR_BYTE : 8'($urandom_range(255));
				end
			endcase
			send_word(FUNC_BYTE, b);
		end
		send_word(FUNC_BYTE, flags);
		send_word(FUNC_BYTE, tail);
	endtask

	task automatic wait_drained();
		while (pending_channels.size() != 0)
			@(posedge clk);
	endtask

	// While hunting, idle gaps and anything but the header are dropped.
	task automatic test_hunting();
		send_word(FUNC_IDLE, 8'hFF);
		send_word(FUNC_BYTE, 8'hFF);
		send_word(FUNC_BYTE, 8'h00);
		send_word(FUNC_BYTE, 8'hF0);
	endtask

	// A frame cut short by a line gap produces nothing; the gap carries the
	// header value to show that its byte is ignored and no frame is started.
	task automatic test_abandoned_frame();
		send_word(FUNC_BYTE, HDR_BYTE);
		send_word(FUNC_BYTE, 8'hA5);
		send_word(FUNC_BYTE, HDR_BYTE);
		send_word(FUNC_BYTE, 8'h5A);
		send_word(FUNC_IDLE, HDR_BYTE);
	endtask

	// One good frame with all-ones, all-zero and header bytes in its payload,
	// and both flag bits set, so failsafe has to win over lost.
	task automatic test_full_frame();
		logic [7:0] flags;
		flags = '0;
		flags[FLAG_LOST]     = 1'b1;
		flags[FLAG_FAILSAFE] = 1'b1;
		send_frame(FILL_MIXED, flags, END_BYTE);
	endtask

	// Frames back to back with neither side ever idling.
	task automatic test_steady_stream();
		steady = 1'b1;
		send_frame(FILL_ONES, 8'h00, END_BYTE);
		send_frame(FILL_ZERO, 8'hFF, END_BYTE);
		send_frame(FILL_RANDOM, 8'($urandom_range(255)), END_BYTE);
		wait_drained();
		steady = 1'b0;
	endtask

	// Mostly well-formed frames with random payload and flags, some with a bad
	// end byte; the rest are frames cut by a gap, line noise and lone gaps.
	// Every kind of burst leaves the parser hunting, so the next frame lines up.
	// Traffic stops once the run as a whole has offered its share of words.
	task automatic test_random_traffic();
		int unsigned pick;
		fill_t       fill;
		logic [7:0]  tail;
		while (words_taken < ITEM_TARGET) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				case ($urandom_range(9))
					0: fill = FILL_ZERO;
					1: fill = FILL_ONES;
					2: fill = FILL_MIXED;
					default: fill = FILL_RANDOM;
				endcase
				tail = ($urandom_range(99) < 88) ? END_BYTE : 8'($urandom_range(255, 1));
				send_frame(fill, 8'($urandom_range(255)), tail);
			end else if (pick < 82) begin
				// Up to every data byte may come before the gap, which then
				// falls where the end byte belongs.
				send_word(FUNC_BYTE, HDR_BYTE);
				repeat ($urandom_range(LAST_DATA, 0))
					send_word(FUNC_BYTE, 8'($urandom_range(255)));
				send_word(FUNC_IDLE, 8'($urandom_range(255)));
			end else if (pick < 92) begin
				repeat ($urandom_range(4, 1))
					send_word(1'($urandom_range(1)), 8'($urandom_range(255)));
				send_word(FUNC_IDLE, 8'($urandom_range(255)));
			end else begin
				send_word(FUNC_IDLE, 8'($urandom_range(255)));
			end
		end
	endtask

	task automatic finish_run();
		push <= 1'b0;
		wait_drained();
		// Let any word the block should not have made come out and be caught.
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d input words, %0d of them inside frames or cutting one short.",
			words_taken, live_words);
		$display("Decoded %0d frames, dropped %0d on a bad end byte, checked %0d channel words.",
			frames_decoded, frames_rejected, channels_checked);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	endtask

	// Reset is held low from the start and released on a rising edge; the flops
	// do not see the release until the following edge.
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_hunting();
		test_abandoned_frame();
		test_full_frame();
		test_steady_stream();
		test_random_traffic();
		finish_run();
	end

endmodule

// ----- filelist.f -----
rtl/core/sbfr_pkg.sv
rtl/core/sbfr_front.sv
rtl/core/sbfr_frame_fifo.sv
rtl/core/sbfr_back.sv
rtl/core/sbus_frame_receiver.sv
dv/tb_top.sv
